[rtl/core/bta_pkg.sv]
// Shared constants, widths and types of the buddy tree allocator.
// No dependencies; bta_ctrl, bta_datapath and buddy_tree_allocator import this package.
package bta_pkg;

	localparam int POOL_PAGES = 1024;
	localparam int OFF_W      = 10;
	localparam int PAGE_W     = 11;
	localparam int NODE_W     = $clog2(2 * POOL_PAGES);
	localparam int TREE_DEPTH = 2 * POOL_PAGES;
	localparam int TREE_NODES = 2 * POOL_PAGES - 1;

	localparam logic [PAGE_W-1:0] POOL_SIZE = PAGE_W'(POOL_PAGES);
	localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
	localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(TREE_NODES);

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} bta_func_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_A_ROOT,
		ST_A_CHECK,
		ST_A_DOWN,
		ST_F_LEAF,
		ST_F_CLIMB,
		ST_UP,
		ST_DONE
	} bta_state_t;

	typedef struct packed {
		logic init;
		logic load;
		logic a_root;
		logic a_check;
		logic a_down;
		logic f_leaf;
		logic f_climb;
		logic up;
		logic res_load;
		logic res_fail;
	} bta_cmd_t;

	typedef struct packed {
		logic init_last;
		logic fit_fail;
		logic whole_pool;
		logic chosen;
		logic out_range;
		logic found;
		logic at_root;
		logic misaligned;
		logic up_last;
	} bta_status_t;

endpackage

[rtl/core/bta_ram.sv]
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.
module bta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[rtl/core/bta_ctrl.sv]
// Sequencer of the buddy tree allocator: walks init, descent, climb and update phases.
// Depends on bta_pkg for the state, command and status types.
module bta_ctrl import bta_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        func,
	input  bta_status_t status,
	output bta_cmd_t    cmd,
	output logic        busy,
	output logic        done
);

	bta_state_t state_q, state_d;
	logic       accept;

	assign accept = start && (state_q == ST_IDLE || state_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (status.init_last) state_d = ST_IDLE;
			end
			ST_IDLE, ST_DONE: begin
				if (accept) begin
					state_d = (bta_func_t'(func) == FUNC_FREE) ? ST_F_LEAF : ST_A_ROOT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_A_ROOT: state_d = ST_A_CHECK;
			ST_A_CHECK: begin
				if (status.fit_fail || status.whole_pool) state_d = ST_DONE;
				else state_d = ST_A_DOWN;
			end
			ST_A_DOWN: begin
				if (status.chosen) state_d = ST_UP;
			end
			ST_F_LEAF: begin
				state_d = status.out_range ? ST_DONE : ST_F_CLIMB;
			end
			ST_F_CLIMB: begin
				if (status.found) begin
					if (status.misaligned || status.at_root) state_d = ST_DONE;
					else state_d = ST_UP;
				end else if (status.at_root) begin
					state_d = ST_DONE;
				end
			end
			ST_UP: begin
				if (status.up_last) state_d = ST_DONE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.load    = accept;
		cmd.init    = (state_q == ST_INIT);
		cmd.a_root  = (state_q == ST_A_ROOT);
		cmd.a_check = (state_q == ST_A_CHECK);
		cmd.a_down  = (state_q == ST_A_DOWN);
		cmd.f_leaf  = (state_q == ST_F_LEAF);
		cmd.f_climb = (state_q == ST_F_CLIMB);
		cmd.up      = (state_q == ST_UP);
		case (state_q)
			ST_A_CHECK: begin
				cmd.res_load = status.fit_fail || status.whole_pool;
				cmd.res_fail = status.fit_fail;
			end
			ST_A_DOWN: begin
				cmd.res_load = status.chosen;
			end
			ST_F_LEAF: begin
				cmd.res_load = status.out_range;
				cmd.res_fail = status.out_range;
			end
			ST_F_CLIMB: begin
				cmd.res_load = status.found || status.at_root;
				cmd.res_fail = status.found ? status.misaligned : status.at_root;
			end
			default: begin
				cmd.res_load = 1'b0;
			end
		endcase
		busy = !(state_q == ST_IDLE || state_q == ST_DONE);
		done = (state_q == ST_DONE);
	end

endmodule

[rtl/core/bta_datapath.sv]
// Datapath of the buddy tree allocator: request registers, node walker, tree RAM, results.
// Depends on bta_pkg and instantiates bta_ram for the free-run tree.
module bta_datapath import bta_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  bta_cmd_t           cmd,
	input  logic               func,
	input  logic [PAGE_W-1:0]  request_pages,
	input  logic [OFF_W-1:0]   block_offset,
	output bta_status_t        status,
	output logic [OFF_W-1:0]   offset,
	output logic [PAGE_W-1:0]  granted_pages,
	output logic               failed
);

	function automatic logic [PAGE_W:0] round_pow2(input logic [PAGE_W-1:0] x);
		logic [PAGE_W-1:0] v;
		v = x - PAGE_W'(1);
		for (int s = 1; s < PAGE_W; s = s * 2) begin
			v = v | (v >> s);
		end
		if (x <= PAGE_W'(1)) begin
			return (PAGE_W+1)'(1);
		end
		return {1'b0, v} + (PAGE_W+1)'(1);
	endfunction

	bta_func_t         func_q;
	logic [PAGE_W-1:0] want_q;
	logic              want_big_q;
	logic [OFF_W-1:0]  boff_q;
	logic [NODE_W-1:0] h_q, h_d;
	logic [PAGE_W-1:0] nsize_q, nsize_d;
	logic [PAGE_W-1:0] cur_q, cur_d;
	logic [OFF_W-1:0]  off_q, off_d;

	logic [OFF_W-1:0]  res_off_q;
	logic [PAGE_W-1:0] res_pages_q;
	logic              res_fail_q;

	logic              we;
	logic [NODE_W-1:0] waddr, raddr_a, raddr_b;
	logic [PAGE_W-1:0] wdata, rd_a, rd_b;

	logic [PAGE_W:0]   want_round;
	logic              pick_left;
	logic [NODE_W-1:0] child, parent, leaf;
	logic [PAGE_W-1:0] csize, psize, pmax, pval, mask;
	logic [PAGE_W:0]   sum;
	logic [OFF_W-1:0]  off_next;

	assign want_round = round_pow2(request_pages);

	// descent choice between the two children
	assign pick_left = (rd_a >= want_q) && ((rd_b < want_q) || (rd_a <= rd_b));
	assign child     = {h_q[NODE_W-2:0], !pick_left};
	assign csize     = nsize_q >> 1;
	assign off_next  = off_q + (pick_left ? '0 : csize[OFF_W-1:0]);

	// buddy merge on the way up
	assign parent = h_q >> 1;
	assign psize  = nsize_q << 1;
	assign sum    = {1'b0, cur_q} + {1'b0, rd_a};
	assign pmax   = (cur_q > rd_a) ? cur_q : rd_a;
	assign pval   = (sum == {1'b0, psize}) ? psize : pmax;

	assign leaf = NODE_W'(boff_q) + NODE_W'(POOL_PAGES);
	assign mask = nsize_q - PAGE_W'(1);

	always_comb begin
		status            = '0;
		status.init_last  = (h_q == LAST_NODE);
		status.fit_fail   = want_big_q || (rd_a < want_q);
		status.whole_pool = (want_q == POOL_SIZE);
		status.chosen     = (csize == want_q);
		status.out_range  = (PAGE_W'(boff_q) >= POOL_SIZE);
		status.found      = (rd_a == '0);
		status.at_root    = (h_q == ROOT_NODE);
		status.misaligned = ((boff_q & mask[OFF_W-1:0]) != '0);
		status.up_last    = (parent == ROOT_NODE);
	end

	always_comb begin
		we      = 1'b0;
		waddr   = h_q;
		wdata   = '0;
		raddr_a = '0;
		raddr_b = '0;
		h_d     = h_q;
		nsize_d = nsize_q;
		cur_d   = cur_q;
		off_d   = off_q;
		if (cmd.init) begin
			// clearing pass: each node gets its full subtree size
			we    = 1'b1;
			wdata = nsize_q;
			h_d   = h_q + NODE_W'(1);
			if ((h_d & h_q) == '0) nsize_d = nsize_q >> 1;
		end
		if (cmd.a_root) begin
			raddr_a = ROOT_NODE;
		end
		if (cmd.a_check) begin
			h_d     = ROOT_NODE;
			nsize_d = POOL_SIZE;
			off_d   = '0;
			raddr_a = NODE_W'(2);
			raddr_b = NODE_W'(3);
			if (!status.fit_fail && status.whole_pool) begin
				we    = 1'b1;
				waddr = ROOT_NODE;
			end
		end
		if (cmd.a_down) begin
			h_d     = child;
			nsize_d = csize;
			off_d   = off_next;
			if (status.chosen) begin
				we      = 1'b1;
				waddr   = child;
				cur_d   = '0;
				raddr_a = child ^ NODE_W'(1);
			end else begin
				raddr_a = {child[NODE_W-2:0], 1'b0};
				raddr_b = {child[NODE_W-2:0], 1'b1};
			end
		end
		if (cmd.f_leaf) begin
			raddr_a = leaf;
			h_d     = leaf;
			nsize_d = PAGE_W'(1);
		end
		if (cmd.f_climb) begin
			if (status.found) begin
				we      = !status.misaligned;
				wdata   = nsize_q;
				cur_d   = nsize_q;
				raddr_a = h_q ^ NODE_W'(1);
			end else if (!status.at_root) begin
				h_d     = parent;
				nsize_d = psize;
				raddr_a = parent;
			end
		end
		if (cmd.up) begin
			we      = 1'b1;
			waddr   = parent;
			wdata   = pval;
			h_d     = parent;
			nsize_d = psize;
			cur_d   = pval;
			raddr_a = parent ^ NODE_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= ROOT_NODE;
			nsize_q <= POOL_SIZE;
		end else begin
			h_q     <= h_d;
			nsize_q <= nsize_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		off_q <= off_d;
		if (cmd.load) begin
			func_q     <= bta_func_t'(func);
			want_q     <= want_round[PAGE_W-1:0];
			want_big_q <= (request_pages > POOL_SIZE);
			boff_q     <= block_offset;
		end
		if (cmd.res_load) begin
			if (cmd.res_fail) begin
				res_off_q   <= (func_q == FUNC_FREE) ? boff_q : '0;
				res_pages_q <= '0;
				res_fail_q  <= 1'b1;
			end else if (func_q == FUNC_FREE) begin
				res_off_q   <= boff_q;
				res_pages_q <= nsize_q;
				res_fail_q  <= 1'b0;
			end else begin
				res_off_q   <= cmd.a_down ? off_next : '0;
				res_pages_q <= want_q;
				res_fail_q  <= 1'b0;
			end
		end
	end

	bta_ram #(
		.WIDTH(PAGE_W),
		.DEPTH(TREE_DEPTH)
	) u_tree (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rd_a),
		.raddr_b (raddr_b),
		.rdata_b (rd_b)
	);

	assign offset        = res_off_q;
	assign granted_pages = res_pages_q;
	assign failed        = res_fail_q;

endmodule

[rtl/core/buddy_tree_allocator.sv]
// Top level of the buddy tree allocator: sequencer plus datapath with the tree RAM.
// Depends on bta_pkg, bta_ctrl, bta_datapath and bta_ram.
//
//  channel  | ports                                    | transfer when
//  ---------+------------------------------------------+-------------------------
//  request  | func, request_pages, block_offset        | start && !busy
//  result   | offset, granted_pages, failed            | done (one cycle, no stall)
//
// Steps: an allocate passes ST_A_ROOT and ST_A_CHECK, then ST_A_DOWN level by
// level down to its block and ST_UP back to the root; a free passes ST_F_LEAF,
// then ST_F_CLIMB up to its block and ST_UP back to the root. The tree is walked
// level by level, as the tree RAM has a single write port and a registered read.
// Reset: arst_n clears the sequencer, then a clearing pass writes all 2047 tree
// nodes, one a cycle, with busy high; no request is taken until it ends.
// Stalls: the receiver cannot hold results off; a new request may be taken in
// the cycle its predecessor's result is shown.
module buddy_tree_allocator import bta_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic [PAGE_W-1:0] request_pages,
	input  logic [OFF_W-1:0]  block_offset,
	output logic              done,
	output logic [OFF_W-1:0]  offset,
	output logic [PAGE_W-1:0] granted_pages,
	output logic              failed
);

	// command and status between the sequencer and the datapath
	bta_cmd_t    cmd;
	bta_status_t status;

	// sequencer: decide the phase, flag when results load, drive busy and done
	bta_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: hold the request, walk the tree, merge buddies, hold the result
	bta_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.func          (func),
		.request_pages (request_pages),
		.block_offset  (block_offset),
		.status        (status),
		.offset        (offset),
		.granted_pages (granted_pages),
		.failed        (failed)
	);

	// a result cycle always leaves the block ready for the next request
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// a failed request releases or grants nothing
	a_fail_no_pages: assert property (@(posedge clk) disable iff (!arst_n)
		(done && failed) |-> (granted_pages == '0))
		else $error("failed result with nonzero size");

	// a served request is a power-of-two block aligned to its size
	a_grant_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !failed) |-> ($onehot(granted_pages) &&
			((PAGE_W'(offset) & (granted_pages - PAGE_W'(1))) == '0)))
		else $error("granted block not a power of two or misaligned");

	// the datapath is driven in at most one phase per cycle
	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.init, cmd.a_root, cmd.a_check, cmd.a_down,
			cmd.f_leaf, cmd.f_climb, cmd.up}))
		else $error("more than one datapath phase active");

endmodule
